### design/assert_macros.svh
// Assertion macros used by task_priority_queue.
// ASSERT_ALWAYS checks a property at every rising clock edge outside reset.
// ASSERT_NEVER checks that an expression is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### design/tpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_pkg: task priority queue shared definitions
// Capacity, field widths, operation and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package tpq_pkg;

	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FIELD_W  = 16;
	localparam int OCC_W    = 6;
	localparam int STAT_W   = 2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// field order makes a plain unsigned compare the service order:
	// priority, then run time, then identifier
	typedef struct packed {
		logic [FIELD_W-1:0] prio;
		logic [FIELD_W-1:0] dur;
		logic [FIELD_W-1:0] id;
	} task_t;

	typedef struct packed {
		logic  push;
		logic  pop;
		task_t item;
	} cell_ctrl_t;

endpackage
`default_nettype wire

### design/task_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// task_priority_queue: bounded min priority queue of tasks
// Sorted chain of cells; head cell always holds the best task.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | kind, task_id, priority_req, duration
//  out     | out_valid/out_stall| status, out_id, out_priority, out_duration,
//          |                    | occupancy
//
// One item per cycle while in_stall is low: every cell compares the new task with
// its own in parallel, so a push or pop updates the whole chain at the accepting edge.
// The result sits in an output register in the cycle after acceptance.
// in_stall is raised only while a finished result waits on out_stall.
// Reset empties the queue (fill count to zero) and clears out_valid; cell contents are untouched.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module task_priority_queue
	import tpq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               kind,
	input  wire logic [FIELD_W-1:0] task_id,
	input  wire logic [FIELD_W-1:0] priority_req,
	input  wire logic [FIELD_W-1:0] duration,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [STAT_W-1:0]       status,
	output logic [FIELD_W-1:0]      out_id,
	output logic [FIELD_W-1:0]      out_priority,
	output logic [FIELD_W-1:0]      out_duration,
	output logic [OCC_W-1:0]        occupancy
);

	logic               accept;
	logic               full;
	logic               empty;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   fill_d;
	logic [STAT_W-1:0]  stat_d;
	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	task_t              res_q;
	logic [OCC_W-1:0]   occ_q;
	cell_ctrl_t         ctrl;
	logic [CAPACITY-1:0] ins;
	task_t              items [CAPACITY];

	// result register frees the input unless it is held by the sink
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (fill_q == CNT_W'(CAPACITY));
	assign empty    = (fill_q == '0);

	// chain control: a push into a full queue and a pop on empty do nothing
	always_comb begin
		ctrl.item.prio = priority_req;
		ctrl.item.dur  = duration;
		ctrl.item.id   = task_id;
		ctrl.push      = accept && (kind == OP_PUSH) && !full;
		ctrl.pop       = accept && (kind == OP_POP) && !empty;
	end

	always_comb begin
		fill_d = fill_q;
		stat_d = ST_OK;
		if (kind == OP_PUSH) begin
			if (full) stat_d = ST_FULL;
			else      fill_d = fill_q + CNT_W'(1);
		end else begin
			if (empty) stat_d = ST_EMPTY;
			else       fill_d = fill_q - CNT_W'(1);
		end
	end

	// ---------------------------------------------------------------- cells
	// cell i is occupied when i < fill; the head cell has no left neighbor,
	// the tail cell shifts in don't-care data on pop
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic  held;
		logic  left_ins;
		task_t left_item;
		task_t right_item;

		assign held = (fill_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign left_ins  = 1'b0;
			assign left_item = ctrl.item;
		end else begin : g_mid
			assign left_ins  = ins[i-1];
			assign left_item = items[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_item = items[i];
		end else begin : g_body
			assign right_item = items[i+1];
		end

		tpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.held       (held),
			.left_ins   (left_ins),
			.left_item  (left_item),
			.right_item (right_item),
			.ins        (ins[i]),
			.item       (items[i])
		);
	end

	// ------------------------------------------------------ count and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) fill_q <= fill_d;
			out_valid_q <= accept || in_stall;
		end
	end

	// payload: popped task comes straight from the head cell
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= stat_d;
			occ_q    <= OCC_W'(fill_d);
			res_q    <= ctrl.pop ? items[0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_id       = res_q.id;
	assign out_priority = res_q.prio;
	assign out_duration = res_q.dur;
	assign occupancy    = occ_q;

	// ----------------------------------------------------------- assertions
	`ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q > CNT_W'(CAPACITY), "fill over capacity")
	`ASSERT_ALWAYS(a_fill_idle, clk, arst_n, !accept |=> $stable(fill_q), "fill moved without item")
	`ASSERT_ALWAYS(a_head_sorted, clk, arst_n, (fill_q >= CNT_W'(2)) |-> (items[0] <= items[1]), "head not best")
	`ASSERT_ALWAYS(a_empty_occ, clk, arst_n, (out_valid_q && status_q == ST_EMPTY) |-> (occ_q == '0), "empty pop with tasks held")

endmodule
`default_nettype wire

### design/tpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_cell: one slot of the sorted task chain
// Keeps, takes the new task, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module tpq_cell
	import tpq_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_ctrl_t ctrl,
	input  wire logic       held,
	input  wire logic       left_ins,
	input  wire task_t      left_item,
	input  wire task_t      right_item,
	output logic            ins,
	output task_t           item
);

	task_t item_q;

	// slot at or past the insert point
	assign ins  = !held || (ctrl.item < item_q);
	assign item = item_q;

	always_ff @(posedge clk) begin
		if (ctrl.push && ins) begin
			item_q <= left_ins ? left_item : ctrl.item;
		end else if (ctrl.pop) begin
			item_q <= right_item;
		end
	end

endmodule
`default_nettype wire

### tb/tb_task_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_task_priority_queue: self-checking bench for the task priority queue
// Pushes and pops go in under random idling on both channels. A behavioral
// store of held tasks predicts every result, and each result is checked
// field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_task_priority_queue;
	import tpq_pkg::*;

	localparam int RESET_CYCLES = 11;
	localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
	localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all
	localparam int DRAIN_CYCLES = 8;     // result register is one deep
	localparam int MAX_PRINTS   = 100;

	typedef struct packed {
		logic [FIELD_W-1:0] id;
		logic [FIELD_W-1:0] prio;
		logic [FIELD_W-1:0] dur;
	} job_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FIELD_W-1:0] id;
		logic [FIELD_W-1:0] prio;
		logic [FIELD_W-1:0] dur;
		logic [OCC_W-1:0]   occ;
	} pop_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic kind;
	logic [FIELD_W-1:0] task_id;
	logic [FIELD_W-1:0] priority_req;
	logic [FIELD_W-1:0] duration;
	logic out_valid;
	logic out_stall;
	logic [STAT_W-1:0]  status;
	logic [FIELD_W-1:0] out_id;
	logic [FIELD_W-1:0] out_priority;
	logic [FIELD_W-1:0] out_duration;
	logic [OCC_W-1:0]   occupancy;

	// shadow copy of the queue contents, unordered like a bag
	job_t        held_jobs [CAPACITY];
	int          held_count;
	pop_result_t expected_results [$];

	int mismatches;
	int quiet_cycles;
	bit handshake_seen;
	bit tx_bursts;   // sender idles at random
	bit rx_bursts;   // receiver stalls at random
	bit hold_req;    // ask the receiver for one long hold-off

	task_priority_queue i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.task_id      (task_id),
		.priority_req (priority_req),
		.duration     (duration),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_id       (out_id),
		.out_priority (out_priority),
		.out_duration (out_duration),
		.occupancy    (occupancy)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Service order and the queue predictor
	// ------------------------------------------------------------------------

	// priority first, then run time, then identifier; smaller wins
	function automatic bit served_first(job_t a, job_t b);
		if (a.prio != b.prio)
			return a.prio < b.prio;
		if (a.dur != b.dur)
			return a.dur < b.dur;
		return a.id < b.id;
	endfunction

	function automatic void predict_queue_op(logic op, job_t job);
		pop_result_t r;
		int best;
		r = '0;
		r.status = ST_OK;
		if (op == OP_PUSH) begin
			if (held_count >= CAPACITY) begin
				r.status = ST_FULL;   // dropped, store unchanged
			end else begin
				held_jobs[held_count] = job;
				held_count++;
			end
		end else if (held_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			best = 0;
			for (int i = 1; i < held_count; i++)
				if (served_first(held_jobs[i], held_jobs[best]))
					best = i;
			r.id   = held_jobs[best].id;
			r.prio = held_jobs[best].prio;
			r.dur  = held_jobs[best].dur;
			held_count--;
			held_jobs[best] = held_jobs[held_count];
		end
		r.occ = held_count[OCC_W-1:0];
		expected_results.push_back(r);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic job_t make_job(int unsigned id, int unsigned prio, int unsigned dur);
		job_t j;
		j.id   = id[FIELD_W-1:0];
		j.prio = prio[FIELD_W-1:0];
		j.dur  = dur[FIELD_W-1:0];
		return j;
	endfunction

	// mostly full range; a good share from a tiny range so ties and exact
	// duplicates come up often; the rest at the extremes
	function automatic logic [FIELD_W-1:0] pick_value();
		int unsigned spread;
		logic [FIELD_W-1:0] v;
		spread = $urandom_range(0, 9);
		if (spread < 5)
			v = FIELD_W'($urandom_range(0, 65535));
		else if (spread < 8)
			v = FIELD_W'($urandom_range(0, 3));
		else
			v = $urandom_range(0, 1) ? '1 : '0;
		return v;
	endfunction

	function automatic job_t pick_job();
		job_t j;
		j.id   = pick_value();
		j.prio = pick_value();
		j.dur  = pick_value();
		return j;
	endfunction

	task automatic idle_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// called at a rising edge; returns at the edge that takes the item, or after a random idle
	task automatic send_item(input logic op, input job_t job);
		in_valid     <= 1'b1;
		kind         <= op;
		task_id      <= job.id;
		priority_req <= job.prio;
		duration     <= job.dur;
		// inputs move only at rising edges, so the level at the falling edge
		// is what the next rising edge sees
		do @(negedge clk); while (in_stall !== 1'b0);
		predict_queue_op(op, job);
		@(posedge clk);
		if (tx_bursts && $urandom_range(0, 5) == 0)
			idle_input($urandom_range(1, 18));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// push/pop mix in stretches: push-heavy stretches run the queue up to
	// full and beyond, pop-heavy ones drain it and pop on empty
	task automatic run_random_mix(input int count);
		int unsigned push_pct;
		int stretch;
		int sent;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 2))
				0: push_pct = 15;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			stretch = $urandom_range(20, 80);
			for (int n = 0; n < stretch && sent < count; n++) begin
				send_item(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, pick_job());
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// field extremes, bit patterns, every tie rule, duplicates, empty pops
	task automatic test_directed();
		send_item(OP_POP, pick_job());                       // pop on empty
		send_item(OP_PUSH, make_job(16'h1234, 5, 9));
		send_item(OP_PUSH, make_job(16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(OP_PUSH, make_job(0, 0, 0));
		send_item(OP_PUSH, make_job(10, 7, 3));
		send_item(OP_PUSH, make_job(11, 7, 2));              // same priority, shorter
		send_item(OP_PUSH, make_job(9, 7, 2));               // same prio/dur, lower id
		send_item(OP_PUSH, make_job(40, 7, 2));
		send_item(OP_PUSH, make_job(40, 7, 2));              // exact duplicate
		send_item(OP_PUSH, make_job(16'hAAAA, 16'h5555, 16'hAAAA));
		send_item(OP_PUSH, make_job(16'h5555, 16'hAAAA, 16'h5555));
		for (int n = 0; n < 12; n++)                         // drain, then two more
			send_item(OP_POP, pick_job());
	endtask

	// fill past capacity, then drain past empty, a few times over
	task automatic test_fill_drain();
		for (int round = 0; round < 3; round++) begin
			for (int n = 0; n < CAPACITY + 3; n++)
				send_item(OP_PUSH, pick_job());
			for (int n = 0; n < CAPACITY + 2; n++)
				send_item(OP_POP, pick_job());
		end
	endtask

	task automatic test_random_mix();
		run_random_mix(750);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		tx_bursts = 1'b0;
		rx_bursts = 1'b0;
		hold_req  = 1'b1;
		for (int n = 0; n < 40; n++)
			send_item(OP_PUSH, pick_job());
		run_random_mix(20);
		tx_bursts = 1'b1;
		rx_bursts = 1'b1;
	endtask

	// sender stops until the last result is out, then starts again
	task automatic test_sender_pause();
		for (int round = 0; round < 4; round++) begin
			run_random_mix($urandom_range(10, 20));
			wait_drained();
		end
	endtask

	// closing stretch: back to back on both sides
	task automatic test_streaming();
		tx_bursts = 1'b0;
		rx_bursts = 1'b0;
		run_random_mix(200);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stall bursts, plus the long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checking, at the falling edge before the taking edge
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < MAX_PRINTS)
			$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(negedge clk) begin : check_results
		pop_result_t want;
		if (arst_n === 1'b1) begin
			handshake_seen = (in_valid && in_stall === 1'b0) ||
				(out_valid === 1'b1 && !out_stall);
			if (out_valid === 1'b1 && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing pending", 32'(out_id), 32'(0));
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (out_id !== want.id)
						report_mismatch("out_id", 32'(out_id), 32'(want.id));
					if (out_priority !== want.prio)
						report_mismatch("out_priority", 32'(out_priority),
							32'(want.prio));
					if (out_duration !== want.dur)
						report_mismatch("out_duration", 32'(out_duration),
							32'(want.dur));
					if (occupancy !== want.occ)
						report_mismatch("occupancy", 32'(occupancy), 32'(want.occ));
				end
			end
		end
	end

	// watchdog: any handshake on either side restarts the count
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (handshake_seen)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL task_priority_queue");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		kind           = OP_PUSH;
		task_id        = '0;
		priority_req   = '0;
		duration       = '0;
		held_count     = 0;
		mismatches     = 0;
		quiet_cycles   = 0;
		handshake_seen = 1'b0;
		tx_bursts      = 1'b0;
		rx_bursts      = 1'b0;
		hold_req       = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_bursts = 1'b1;
		rx_bursts = 1'b1;

		test_directed();
		test_fill_drain();
		test_random_mix();
		test_backpressure();
		test_sender_pause();
		test_streaming();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS task_priority_queue");
		else
			$display("FAIL task_priority_queue");
		$finish;
	end

endmodule
